### hdl/dra_pkg.sv
// shared types and constants of the descriptor range allocator
`timescale 1ns / 1ps
package dra_pkg;

    localparam int CNT_W  = 20;
    localparam int INC_W  = 12;
    localparam int ADDR_W = 64;
    localparam int POS_W  = CNT_W + 1;
    localparam int PROD_W = POS_W + INC_W;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    localparam logic [1:0] REG_HEAP_CAPACITY    = 2'd0;
    localparam logic [1:0] REG_HANDLE_INCREMENT = 2'd1;
    localparam logic [1:0] REG_CPU_BASE         = 2'd2;
    localparam logic [1:0] REG_GPU_BASE         = 2'd3;

    localparam logic [INC_W-1:0] HANDLE_INCREMENT_RESET = 12'd32;

    typedef enum logic [1:0] {
        CMD_ALLOC      = 2'd0,
        CMD_RELEASE    = 2'd1,
        CMD_CPU_HANDLE = 2'd2,
        CMD_GPU_HANDLE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ZERO_COUNT = 3'd1,
        ST_NO_MEMORY  = 3'd2,
        ST_NOT_INIT   = 3'd3,
        ST_TABLE_FULL = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_SHIFT,
        S_BUMP,
        S_ADD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]       command;
        logic [CNT_W-1:0] req_count;
        logic [CNT_W-1:0] req_offset;
        logic [CNT_W-1:0] elem_index;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic [CNT_W-1:0]  range_offset;
        logic [CNT_W-1:0]  range_count;
        logic              reused;
        logic [ADDR_W-1:0] handle_addr;
    } t_rsp;

    typedef struct packed {
        logic [CNT_W-1:0]  heap_capacity;
        logic [INC_W-1:0]  handle_increment;
        logic [ADDR_W-1:0] cpu_base;
        logic [ADDR_W-1:0] gpu_base;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] offset;
        logic [CNT_W-1:0] count;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic    load_req;
        logic    search_start;
        logic    search_next;
        logic    take_hit;
        logic    shift;
        logic    shrink;
        logic    bump;
        logic    push;
        logic    mul;
        logic    add;
        logic    set_status;
        t_status status;
        logic    emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic cap_zero;
        logic cnt_zero;
        logic len_zero;
        logic table_full;
        logic hit;
        logic ptr_zero;
        logic more;
        logic room;
        logic out_free;
    } t_dp_sts;

endpackage

### hdl/dra_regs.sv
// apb configuration registers of the descriptor range allocator
`timescale 1ns / 1ps
module dra_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dra_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dra_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dra_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output dra_pkg::t_cfg                  o_cfg
);
    import dra_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{heap_capacity: '0, handle_increment: HANDLE_INCREMENT_RESET,
                       cpu_base: '0, gpu_base: '0};
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_HEAP_CAPACITY:    r_cfg.heap_capacity    <= pwdata[CNT_W-1:0];
                REG_HANDLE_INCREMENT: r_cfg.handle_increment <= pwdata[INC_W-1:0];
                REG_CPU_BASE:         r_cfg.cpu_base         <= pwdata;
                REG_GPU_BASE:         r_cfg.gpu_base         <= pwdata;
                default:              r_cfg.gpu_base         <= r_cfg.gpu_base;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HEAP_CAPACITY:    prdata = APB_DATA_W'(r_cfg.heap_capacity);
            REG_HANDLE_INCREMENT: prdata = APB_DATA_W'(r_cfg.handle_increment);
            REG_CPU_BASE:         prdata = r_cfg.cpu_base;
            REG_GPU_BASE:         prdata = r_cfg.gpu_base;
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/dra_dp.sv
// datapath: request register, free table, bump cursor, handle math, output register
`timescale 1ns / 1ps
module dra_dp #(
    parameter int FREE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dra_pkg::t_req    i_req,
    input  dra_pkg::t_cfg    i_cfg,
    input  dra_pkg::t_dp_cmd i_cmd,
    output dra_pkg::t_dp_sts o_sts,
    input  logic             i_rsp_stall,
    output logic             o_rsp_valid,
    output dra_pkg::t_rsp    o_rsp
);
    import dra_pkg::*;

    localparam int LW = $clog2(FREE_DEPTH + 1);
    localparam int IW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;

    t_entry mem [FREE_DEPTH];

    t_req              r_req;
    t_rsp              r_res;
    t_rsp              r_out;
    logic              r_out_valid;
    t_entry            r_rd;
    logic [CNT_W-1:0]  r_cursor;
    logic [LW-1:0]     r_free_len;
    logic [LW-1:0]     r_ptr;
    logic [PROD_W-1:0] r_prod;

    logic [LW-1:0]     ptr_inc;
    logic [LW-1:0]     ptr_dec;
    logic [LW-1:0]     len_dec;
    logic              more;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    t_entry            wr_data;
    logic [CNT_W:0]    space;
    logic [POS_W-1:0]  pos;
    logic [ADDR_W-1:0] base;
    logic              out_free;

    assign ptr_inc  = r_ptr + LW'(1);
    assign ptr_dec  = r_ptr - LW'(1);
    assign len_dec  = r_free_len - LW'(1);
    assign more     = ptr_inc < r_free_len;
    assign out_free = !r_out_valid || !i_rsp_stall;
    assign space    = {1'b0, i_cfg.heap_capacity} - {1'b0, r_cursor};
    assign pos      = {1'b0, r_req.req_offset} + {1'b0, r_req.elem_index};
    assign base     = (t_cmd'(r_req.command) == CMD_GPU_HANDLE) ? i_cfg.gpu_base
                                                                : i_cfg.cpu_base;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = ptr_inc[IW-1:0];
        priority if (i_cmd.search_start) begin
            rd_en   = 1'b1;
            rd_addr = len_dec[IW-1:0];
        end else if (i_cmd.search_next) begin
            rd_en   = 1'b1;
            rd_addr = ptr_dec[IW-1:0];
        end else if (i_cmd.take_hit || i_cmd.shift) begin
            rd_en   = more;
            rd_addr = ptr_inc[IW-1:0];
        end else begin
            rd_en   = 1'b0;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_free_len[IW-1:0];
        wr_data = '{offset: r_req.req_offset, count: r_req.req_count};
        priority if (i_cmd.shift) begin
            wr_en   = 1'b1;
            wr_addr = ptr_dec[IW-1:0];
            wr_data = r_rd;
        end else if (i_cmd.push) begin
            wr_en   = 1'b1;
        end else begin
            wr_en   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.search_start) begin
            r_ptr <= len_dec;
        end else if (i_cmd.search_next) begin
            r_ptr <= ptr_dec;
        end else if (i_cmd.take_hit || i_cmd.shift) begin
            r_ptr <= ptr_inc;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(pos) * PROD_W'(i_cfg.handle_increment);
        end
        priority if (i_cmd.set_status) begin
            r_res <= '{status: i_cmd.status, range_offset: '0, range_count: '0,
                       reused: 1'b0, handle_addr: '0};
        end else if (i_cmd.take_hit) begin
            r_res <= '{status: ST_OK, range_offset: r_rd.offset, range_count: r_rd.count,
                       reused: 1'b1, handle_addr: '0};
        end else if (i_cmd.bump) begin
            r_res <= '{status: ST_OK, range_offset: r_cursor, range_count: r_req.req_count,
                       reused: 1'b0, handle_addr: '0};
        end else if (i_cmd.push) begin
            r_res <= '{status: ST_OK, range_offset: '0, range_count: '0,
                       reused: 1'b0, handle_addr: '0};
        end else if (i_cmd.add) begin
            r_res <= '{status: ST_OK, range_offset: '0, range_count: '0,
                       reused: 1'b0, handle_addr: base + ADDR_W'(r_prod)};
        end else begin
            r_res <= r_res;
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_free_len  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.bump) begin
                r_cursor <= r_cursor + r_req.req_count;
            end
            if (i_cmd.shrink) begin
                r_free_len <= len_dec;
            end else if (i_cmd.push) begin
                r_free_len <= r_free_len + LW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.cmd        = t_cmd'(r_req.command);
        o_sts.cap_zero   = i_cfg.heap_capacity == '0;
        o_sts.cnt_zero   = r_req.req_count == '0;
        o_sts.len_zero   = r_free_len == '0;
        o_sts.table_full = r_free_len >= LW'(FREE_DEPTH);
        o_sts.hit        = r_rd.count == r_req.req_count;
        o_sts.ptr_zero   = r_ptr == '0;
        o_sts.more       = more;
        o_sts.room       = !space[CNT_W] && (space[CNT_W-1:0] >= r_req.req_count);
        o_sts.out_free   = out_free;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_len <= LW'(FREE_DEPTH))
        else $error("free table length beyond depth");

    a_shrink_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shrink |=> r_free_len == $past(len_dec))
        else $error("free table did not shrink by one");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result overwrote a waiting result");

    a_hit_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_hit |-> r_rd.count == r_req.req_count)
        else $error("reuse of a range with another count");

endmodule

### hdl/dra_ctrl.sv
// controller state machine of the descriptor range allocator
`timescale 1ns / 1ps
module dra_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  dra_pkg::t_dp_sts i_sts,
    output dra_pkg::t_dp_cmd o_cmd
);
    import dra_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_sts.cmd)
                    CMD_ALLOC: begin
                        priority if (i_sts.cap_zero || i_sts.cnt_zero) n_state = S_DONE;
                        else if (i_sts.len_zero) n_state = S_BUMP;
                        else n_state = S_CHECK;
                    end
                    CMD_RELEASE: n_state = S_DONE;
                    default:     n_state = S_ADD;
                endcase
            end
            S_CHECK: begin
                priority if (i_sts.hit) n_state = i_sts.more ? S_SHIFT : S_DONE;
                else if (i_sts.ptr_zero) n_state = S_BUMP;
                else n_state = S_CHECK;
            end
            S_SHIFT: begin
                if (!i_sts.more) n_state = S_DONE;
            end
            S_BUMP:  n_state = S_DONE;
            S_ADD:   n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = ST_OK;
        o_req_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_req_stall    = 1'b0;
                o_cmd.load_req = i_req_valid;
            end
            S_DECODE: begin
                unique case (i_sts.cmd)
                    CMD_ALLOC: begin
                        priority if (i_sts.cap_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_NOT_INIT;
                        end else if (i_sts.cnt_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_ZERO_COUNT;
                        end else begin
                            o_cmd.search_start = !i_sts.len_zero;
                        end
                    end
                    CMD_RELEASE: begin
                        priority if (i_sts.cnt_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_ZERO_COUNT;
                        end else if (i_sts.table_full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_TABLE_FULL;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    default: o_cmd.mul = 1'b1;
                endcase
            end
            S_CHECK: begin
                if (i_sts.hit) begin
                    o_cmd.take_hit = 1'b1;
                    o_cmd.shrink   = !i_sts.more;
                end else begin
                    o_cmd.search_next = !i_sts.ptr_zero;
                end
            end
            S_SHIFT: begin
                o_cmd.shift  = 1'b1;
                o_cmd.shrink = !i_sts.more;
            end
            S_BUMP: begin
                if (i_sts.room) begin
                    o_cmd.bump = 1'b1;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NO_MEMORY;
                end
            end
            S_ADD:  o_cmd.add  = 1'b1;
            S_DONE: o_cmd.emit = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

### hdl/descriptor_range_allocator.sv
// top level of the descriptor range allocator
// usage:
//   request channel i_req_valid / o_req_stall / i_req carries one command:
//   allocate, release, cpu handle or gpu handle. response channel
//   o_rsp_valid / i_rsp_stall / o_rsp returns exactly one result per request.
//   heap capacity, handle increment and the two base addresses are written
//   over the apb port while no request is in flight.
// steps: release, zero count and not initialized are decided at decode; handles
//   form the product of position and increment, then add the base; allocate
//   with an empty table falls back to a bump, else it searches the table and on
//   a hit moves the entries above the reused one down, or bumps on no hit.
//   one request at a time: the next request is taken at the edge after the
//   response is loaded.
//   the free table memory is read one entry per cycle, newest first, and the
//   entries above a reused one are moved down one per cycle.
// reset clears the cursor and empties the free table; registers take their
//   reset values. a stalled response holds in the output register while the
//   next request is taken; a further result waits until that slot drains.
`timescale 1ns / 1ps
module descriptor_range_allocator #(
    parameter int FREE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    output logic                           o_req_stall,
    input  dra_pkg::t_req                  i_req,
    output logic                           o_rsp_valid,
    input  logic                           i_rsp_stall,
    output dra_pkg::t_rsp                  o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dra_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dra_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dra_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import dra_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    dra_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dra_dp #(
        .FREE_DEPTH (FREE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

### verif/range_allocation_checker.sv
// checker that predicts and compares every response of the descriptor range allocator
`timescale 1ns / 1ps
module range_allocation_checker #(
    parameter int FREE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  logic                           i_req_stall,
    input  dra_pkg::t_req                  i_req,
    input  logic                           i_rsp_valid,
    input  logic                           i_rsp_stall,
    input  dra_pkg::t_rsp                  i_rsp,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [dra_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [dra_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                             o_failures,
    output int                             o_outstanding,
    output int                             o_checked,
    output int                             o_reuse_hits,
    output int                             o_no_memory,
    output int                             o_table_full
);
    import dra_pkg::*;

    localparam int MAX_REPORTS = 10;

    t_cfg       heap_cfg;
    logic [CNT_W-1:0] bump_cursor;
    int         free_len;
    t_entry     free_table [FREE_DEPTH];
    t_rsp       owed_results [$];
    t_rsp       want;
    t_rsp       predicted;

    int failures   = 0;
    int checked    = 0;
    int reuse_hits = 0;
    int no_memory  = 0;
    int table_full = 0;
    int owed_count = 0;

    assign o_failures    = failures;
    assign o_outstanding = owed_count;
    assign o_checked     = checked;
    assign o_reuse_hits  = reuse_hits;
    assign o_no_memory   = no_memory;
    assign o_table_full  = table_full;

    function automatic t_rsp allocation_outcome(input t_req rq);
        t_rsp r;
        int i;
        int hit;
        logic [CNT_W:0] pos;
        r = '0;
        hit = -1;
        case (rq.command)
            CMD_ALLOC: begin
                if (heap_cfg.heap_capacity == '0) begin
                    r.status = ST_NOT_INIT;
                end else if (rq.req_count == '0) begin
                    r.status = ST_ZERO_COUNT;
                end else begin
                    // newest entry with the exact count wins
                    for (i = free_len - 1; i >= 0; i--) begin
                        if (hit < 0 && free_table[i].count == rq.req_count) hit = i;
                    end
                    if (hit >= 0) begin
                        r.status       = ST_OK;
                        r.range_offset = free_table[hit].offset;
                        r.range_count  = free_table[hit].count;
                        r.reused       = 1'b1;
                        for (i = hit; i < free_len - 1; i++) free_table[i] = free_table[i + 1];
                        free_len--;
                    end else if (bump_cursor > heap_cfg.heap_capacity ||
                                 heap_cfg.heap_capacity - bump_cursor < rq.req_count) begin
                        r.status = ST_NO_MEMORY;
                    end else begin
                        r.status       = ST_OK;
                        r.range_offset = bump_cursor;
                        r.range_count  = rq.req_count;
                        bump_cursor    = bump_cursor + rq.req_count;
                    end
                end
            end
            CMD_RELEASE: begin
                if (rq.req_count == '0) begin
                    r.status = ST_ZERO_COUNT;
                end else if (free_len >= FREE_DEPTH) begin
                    r.status = ST_TABLE_FULL;
                end else begin
                    free_table[free_len].offset = rq.req_offset;
                    free_table[free_len].count  = rq.req_count;
                    free_len++;
                end
            end
            default: begin
                pos = {1'b0, rq.req_offset} + {1'b0, rq.elem_index};
                r.handle_addr = ((rq.command == CMD_CPU_HANDLE) ? heap_cfg.cpu_base
                                                                : heap_cfg.gpu_base)
                              + 64'(pos) * 64'(heap_cfg.handle_increment);
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            heap_cfg.heap_capacity    = '0;
            heap_cfg.handle_increment = HANDLE_INCREMENT_RESET;
            heap_cfg.cpu_base         = '0;
            heap_cfg.gpu_base         = '0;
            bump_cursor = '0;
            free_len    = 0;
            owed_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:3])
                    REG_HEAP_CAPACITY:    heap_cfg.heap_capacity    = i_pwdata[CNT_W-1:0];
                    REG_HANDLE_INCREMENT: heap_cfg.handle_increment = i_pwdata[INC_W-1:0];
                    REG_CPU_BASE:         heap_cfg.cpu_base         = i_pwdata;
                    REG_GPU_BASE:         heap_cfg.gpu_base         = i_pwdata;
                    default: ;
                endcase
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (owed_results.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("%0t: response %h arrived with no request pending",
                                 $time, i_rsp);
                end else begin
                    want = owed_results.pop_front();
                    checked++;
                    if (i_rsp.status !== want.status ||
                        i_rsp.range_offset !== want.range_offset ||
                        i_rsp.range_count !== want.range_count ||
                        i_rsp.reused !== want.reused ||
                        i_rsp.handle_addr !== want.handle_addr) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $display("%0t: mismatch exp/act status %0d/%0d offset %h/%h count %h/%h",
                                     $time, want.status, i_rsp.status,
                                     want.range_offset, i_rsp.range_offset,
                                     want.range_count, i_rsp.range_count);
                            $display("    reused %b/%b addr %h/%h",
                                     want.reused, i_rsp.reused,
                                     want.handle_addr, i_rsp.handle_addr);
                        end
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                predicted = allocation_outcome(i_req);
                if (predicted.reused) reuse_hits++;
                if (predicted.status == ST_NO_MEMORY) no_memory++;
                if (predicted.status == ST_TABLE_FULL) table_full++;
                owed_results.insert(owed_results.size(), predicted);
            end
        end
        owed_count = owed_results.size();
    end

endmodule

### verif/testbench.sv
// top of the descriptor range allocator testbench: stimulus, flow control and verdict
`timescale 1ns / 1ps
module testbench;
    import dra_pkg::*;

    localparam int FREE_DEPTH      = 16;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int SETTLE_CYCLES   = 2 * FREE_DEPTH + 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_ITEMS     = 220;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_stall;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_stall = 1'b0;
    t_rsp o_rsp;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    int failures;
    int outstanding;
    int checked;
    int reuse_hits;
    int no_memory_hits;
    int table_full_hits;

    int idle_pct = 0;
    int stall_pct = 0;
    int requests_sent = 0;
    int heap_settings = 0;
    int cycle_count;
    logic hold_off_token = 1'b0;
    logic hold_off_seen = 1'b0;
    int hold_off_left = 0;

    descriptor_range_allocator #(
        .FREE_DEPTH(FREE_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_stall(o_req_stall),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_stall(i_rsp_stall),
        .o_rsp      (o_rsp),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    range_allocation_checker #(
        .FREE_DEPTH(FREE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_stall  (o_req_stall),
        .i_req        (i_req),
        .i_rsp_valid  (o_rsp_valid),
        .i_rsp_stall  (i_rsp_stall),
        .i_rsp        (o_rsp),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_failures   (failures),
        .o_outstanding(outstanding),
        .o_checked    (checked),
        .o_reuse_hits (reuse_hits),
        .o_no_memory  (no_memory_hits),
        .o_table_full (table_full_hits)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // response side: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off_token != hold_off_seen) begin
            hold_off_seen <= hold_off_token;
            hold_off_left <= HOLD_OFF_CYCLES;
            i_rsp_stall   <= 1'b1;
        end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
            i_rsp_stall   <= 1'b1;
        end else begin
            i_rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic t_req request_of(input t_cmd cmd, input logic [CNT_W-1:0] cnt,
                                        input logic [CNT_W-1:0] off,
                                        input logic [CNT_W-1:0] idx);
        t_req rq;
        rq.command    = cmd;
        rq.req_count  = cnt;
        rq.req_offset = off;
        rq.elem_index = idx;
        return rq;
    endfunction

    // mostly small counts so that releases get reused, with rare extremes
    function automatic t_req random_request(input int release_pct);
        t_req rq;
        int pick;
        int size_pick;
        pick = $urandom_range(0, 99);
        size_pick = $urandom_range(0, 99);
        if (pick < release_pct) rq.command = CMD_RELEASE;
        else if (pick < release_pct + 15)
            rq.command = ($urandom_range(0, 1) != 0) ? CMD_CPU_HANDLE : CMD_GPU_HANDLE;
        else rq.command = CMD_ALLOC;
        if (size_pick < 3) rq.req_count = '0;
        else if (size_pick < 8) rq.req_count = CNT_W'($urandom_range(0, 1048575));
        else if (size_pick < 11) rq.req_count = CNT_W'($urandom_range(1048560, 1048575));
        else rq.req_count = CNT_W'($urandom_range(1, 12));
        rq.req_offset = CNT_W'($urandom_range(0, 1048575));
        rq.elem_index = CNT_W'($urandom_range(0, 1048575));
        return rq;
    endfunction

    // valid stays high across back-to-back requests
    task automatic send_request(input t_req rq);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic wait_until_drained();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_heap(input logic [CNT_W-1:0] capacity,
                                input logic [INC_W-1:0] increment,
                                input logic [ADDR_W-1:0] cpu_addr,
                                input logic [ADDR_W-1:0] gpu_addr);
        logic [APB_DATA_W-1:0] value [4];
        int r;
        value[REG_HEAP_CAPACITY]    = APB_DATA_W'(capacity);
        value[REG_HANDLE_INCREMENT] = APB_DATA_W'(increment);
        value[REG_CPU_BASE]         = cpu_addr;
        value[REG_GPU_BASE]         = gpu_addr;
        for (r = 0; r < 4; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= APB_ADDR_W'(r << 3);
            pwdata  <= value[r];
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        heap_settings++;
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("run stopped after %0d cycles with %0d responses outstanding",
                 cycle_count, outstanding);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int i;
        int phase;
        int release_pct;
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // heap not initialized yet
        send_request(request_of(CMD_ALLOC, 20'd5, '0, '0));
        send_request(request_of(CMD_ALLOC, '0, '0, '0));
        send_request(request_of(CMD_CPU_HANDLE, '0, CNT_MAX, CNT_MAX));
        wait_until_drained();
        program_heap(20'd100, 12'hFFF, '1, 64'h8000_0000_0000_0001);

        send_request(request_of(CMD_ALLOC, '0, '0, '0));
        send_request(request_of(CMD_RELEASE, '0, CNT_MAX, '0));
        send_request(request_of(CMD_ALLOC, 20'd60, '0, '0));
        send_request(request_of(CMD_ALLOC, 20'd50, '0, '0));
        send_request(request_of(CMD_GPU_HANDLE, '0, CNT_MAX, CNT_MAX));
        for (i = 0; i < FREE_DEPTH; i++) begin
            if (i == 0) send_request(request_of(CMD_RELEASE, CNT_MAX, CNT_MAX, '0));
            else send_request(request_of(CMD_RELEASE, CNT_W'(i % 4 + 1), CNT_W'(i * 5), '0));
        end
        send_request(request_of(CMD_RELEASE, 20'd7, 20'd3, '0));
        send_request(request_of(CMD_ALLOC, 20'd2, '0, '0));
        send_request(request_of(CMD_ALLOC, CNT_MAX, '0, '0));
        wait_until_drained();
        // capacity below the cursor
        program_heap(20'd50, '0, '0, '1);
        send_request(request_of(CMD_ALLOC, 20'd9, '0, '0));

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_until_drained();
            case (phase)
                0: program_heap(CNT_MAX, 12'd32, {$urandom, $urandom}, {$urandom, $urandom});
                1: program_heap(CNT_W'($urandom_range(1, 4000)), '1, '1, '0);
                2: program_heap(CNT_MAX, '0, {$urandom, $urandom}, {$urandom, $urandom});
                3: program_heap('0, INC_W'($urandom), {$urandom, $urandom}, '1);
                4: program_heap(CNT_W'($urandom), INC_W'($urandom), '0,
                                {$urandom, $urandom});
                default: program_heap(CNT_MAX, INC_W'($urandom), '1, '1);
            endcase
            case (phase % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 74;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 74;
                end
                default: begin
                    idle_pct = 14;
                    stall_pct = 14;
                end
            endcase
            release_pct = (phase % 2 != 0) ? 45 : 30;
            if (phase == 0) hold_off_token <= ~hold_off_token;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (phase == 2 && i == PHASE_ITEMS / 2) wait_until_drained();
                send_request(random_request(release_pct));
            end
        end

        wait_until_drained();
        $display("sent %0d requests under %0d heap settings, %0d responses checked",
                 requests_sent, heap_settings, checked);
        $display("reused ranges %0d, out of memory %0d, free table full %0d",
                 reuse_hits, no_memory_hits, table_full_hits);
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
hdl/dra_pkg.sv
hdl/dra_regs.sv
hdl/dra_dp.sv
hdl/dra_ctrl.sv
hdl/descriptor_range_allocator.sv
verif/range_allocation_checker.sv
verif/testbench.sv
